// File: src/qocr_pkg.sv
// Package for the smallest-three quaternion restore block.
// Holds the fixed-point widths, the square-root pipeline sizing and shared types.
// No dependencies.
package qocr_pkg;

  // Fraction bits of the signed fixed-point components (Q2.30 by default).
  localparam int FRAC_BITS = 30;

  // Width of one component and of the omitted-slot index.
  localparam int DW    = 32;
  localparam int IDX_W = 8;

  // Width of a square and of the sum of three squares.
  localparam int SQ_W = 2 * DW;

  // The value one at twice the fraction bits, i.e. the scale of a square.
  localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * FRAC_BITS);

  // Square-root sizing: the radicand reaches 2^(2*FRAC_BITS), so the root
  // needs FRAC_BITS+1 bits. Two root bits are resolved per pipeline stage.
  localparam int SQ_STEPS   = FRAC_BITS + 1;
  localparam int SQ_STAGES  = (SQ_STEPS + 1) / 2;
  localparam int QW         = 2 * SQ_STAGES;
  localparam int RW         = 2 * QW;
  localparam int REM_W      = QW + 2;

  // Largest index that names a component; anything above gives zeros.
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(3);

  // Omitted-slot codes.
  localparam logic [1:0] OMIT_X = 2'd0;
  localparam logic [1:0] OMIT_Y = 2'd1;
  localparam logic [1:0] OMIT_Z = 2'd2;
  localparam logic [1:0] OMIT_W = 2'd3;

  typedef logic signed [DW-1:0] comp_t;

  // Side data that travels alongside the arithmetic through every stage.
  typedef struct packed {
    logic             ok;
    logic [1:0]       sel;
    comp_t [2:0]      comp;
  } meta_t;

endpackage

// File: src/quaternion_omitted_component_restore.sv
// Smallest-three quaternion restore: places three transmitted components and
// rebuilds the omitted one as a pipelined floor square root of (1 - sum of squares).
// Depends on qocr_pkg.

//  Channel   Ports                                   Transfer
//  --------  --------------------------------------  ------------------------------
//  input     start, busy, in_omitted_index,          start high while busy is low
//            in_comp_first/second/third
//  result    out_valid, out_quat_x/y/z/w             one cycle, out_valid high
//
// The block accepts one transaction in every clock cycle; busy is always low.
// A result reaches the result ports through these registers in order: the
// magnitude register loaded at the accepting edge, the squares, two summing
// adds, the radicand, the SQ_STAGES (16) stages of the square-root pipeline,
// which resolves two root bits per stage, and the output register.
// rst_n is synchronous and active low; it clears the valid bits of every
// stage, so no result is produced for anything in flight at reset.
// The receiver cannot stall, so the pipeline advances on every clock.
module quaternion_omitted_component_restore (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [qocr_pkg::IDX_W-1:0] in_omitted_index,
  input  logic signed [qocr_pkg::DW-1:0] in_comp_first,
  input  logic signed [qocr_pkg::DW-1:0] in_comp_second,
  input  logic signed [qocr_pkg::DW-1:0] in_comp_third,
  output logic                     out_valid,
  output logic signed [qocr_pkg::DW-1:0] out_quat_x,
  output logic signed [qocr_pkg::DW-1:0] out_quat_y,
  output logic signed [qocr_pkg::DW-1:0] out_quat_z,
  output logic signed [qocr_pkg::DW-1:0] out_quat_w
);
  import qocr_pkg::*;

  // Front end: magnitudes, squares, sums and radicand.
  logic                a_vld_r;
  meta_t               a_meta_r;
  logic [DW-1:0]       a_mag_r [3];

  logic                b_vld_r;
  meta_t               b_meta_r;
  logic [SQ_W-1:0]     b_sq_r [3];

  logic                c_vld_r;
  meta_t               c_meta_r;
  logic [SQ_W-1:0]     c_part_r;
  logic [SQ_W-1:0]     c_sq2_r;

  logic                d_vld_r;
  meta_t               d_meta_r;
  logic [SQ_W-1:0]     d_sum_r;

  // Square-root pipeline: index 0 holds the radicand, index SQ_STAGES the root.
  logic [SQ_STAGES:0]  s_vld_r;
  meta_t               s_meta_r [SQ_STAGES+1];
  logic [RW-1:0]       s_rad_r  [SQ_STAGES+1];
  logic [REM_W-1:0]    s_rem_r  [SQ_STAGES+1];
  logic [QW-1:0]       s_root_r [SQ_STAGES+1];

  logic [RW-1:0]       s_rad_nxt  [SQ_STAGES+1];
  logic [REM_W-1:0]    s_rem_nxt  [SQ_STAGES+1];
  logic [QW-1:0]       s_root_nxt [SQ_STAGES+1];

  meta_t               in_meta;
  logic [DW-1:0]       in_mag [3];

  logic                out_valid_r;
  comp_t               out_x_r, out_y_r, out_z_r, out_w_r;
  comp_t               out_x_nxt, out_y_nxt, out_z_nxt, out_w_nxt;
  comp_t               root_out;

  // The pipeline never stalls, so the block is always ready.
  assign busy = 1'b0;

  // Input decode and magnitudes. Negating the most negative word yields 2^31,
  // which is exactly its magnitude when read as unsigned.
  always_comb begin
    in_meta.ok      = (in_omitted_index <= IDX_MAX);
    in_meta.sel     = in_omitted_index[1:0];
    in_meta.comp[0] = in_comp_first;
    in_meta.comp[1] = in_comp_second;
    in_meta.comp[2] = in_comp_third;
    for (int i = 0; i < 3; i++) begin
      in_mag[i] = in_meta.comp[i][DW-1] ? (~in_meta.comp[i] + DW'(1)) : in_meta.comp[i];
    end
  end

  // Radicand and digit-by-digit square root, two root bits per stage.
  always_comb begin
    logic [RW-1:0]    rad;
    logic [REM_W-1:0] rem;
    logic [QW-1:0]    root;
    logic [REM_W-1:0] trial;
    // A sum of squares at or above one clamps the rebuilt component to zero.
    s_rad_nxt[0]  = (d_sum_r >= ONE_SQ) ? '0 : RW'(ONE_SQ - d_sum_r);
    s_rem_nxt[0]  = '0;
    s_root_nxt[0] = '0;
    for (int k = 1; k <= SQ_STAGES; k++) begin
      rad  = s_rad_r[k-1];
      rem  = s_rem_r[k-1];
      root = s_root_r[k-1];
      for (int t = 0; t < 2; t++) begin
        rem   = {rem[REM_W-3:0], rad[RW-1:RW-2]};
        rad   = {rad[RW-3:0], 2'b00};
        trial = {root, 2'b01};
        if (rem >= trial) begin
          rem  = rem - trial;
          root = {root[QW-2:0], 1'b1};
        end else begin
          root = {root[QW-2:0], 1'b0};
        end
      end
      s_rad_nxt[k]  = rad;
      s_rem_nxt[k]  = rem;
      s_root_nxt[k] = root;
    end
  end

  // Output assembly: the three transmitted components fill the slots in
  // order around the rebuilt one. An index above three gives all zeros.
  always_comb begin
    root_out  = DW'(s_root_r[SQ_STAGES]);
    out_x_nxt = '0;
    out_y_nxt = '0;
    out_z_nxt = '0;
    out_w_nxt = '0;
    if (s_meta_r[SQ_STAGES].ok) begin
      unique case (s_meta_r[SQ_STAGES].sel)
        OMIT_X: begin
          out_x_nxt = root_out;
          out_y_nxt = s_meta_r[SQ_STAGES].comp[0];
          out_z_nxt = s_meta_r[SQ_STAGES].comp[1];
          out_w_nxt = s_meta_r[SQ_STAGES].comp[2];
        end
        OMIT_Y: begin
          out_x_nxt = s_meta_r[SQ_STAGES].comp[0];
          out_y_nxt = root_out;
          out_z_nxt = s_meta_r[SQ_STAGES].comp[1];
          out_w_nxt = s_meta_r[SQ_STAGES].comp[2];
        end
        OMIT_Z: begin
          out_x_nxt = s_meta_r[SQ_STAGES].comp[0];
          out_y_nxt = s_meta_r[SQ_STAGES].comp[1];
          out_z_nxt = root_out;
          out_w_nxt = s_meta_r[SQ_STAGES].comp[2];
        end
        OMIT_W: begin
          out_x_nxt = s_meta_r[SQ_STAGES].comp[0];
          out_y_nxt = s_meta_r[SQ_STAGES].comp[1];
          out_z_nxt = s_meta_r[SQ_STAGES].comp[2];
          out_w_nxt = root_out;
        end
        default: begin
          out_x_nxt = '0;
        end
      endcase
    end
  end

  // Valid bits: the only state that reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      d_vld_r     <= 1'b0;
      s_vld_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      a_vld_r     <= start && !busy;
      b_vld_r     <= a_vld_r;
      c_vld_r     <= b_vld_r;
      d_vld_r     <= c_vld_r;
      s_vld_r     <= {s_vld_r[SQ_STAGES-1:0], d_vld_r};
      out_valid_r <= s_vld_r[SQ_STAGES];
    end
  end

  // Data path registers, loaded every cycle. The operands of each square are
  // zero-extended magnitudes, so the product is an exact 32 by 32 bit one.
  always_ff @(posedge clk) begin
    a_meta_r <= in_meta;
    b_meta_r <= a_meta_r;
    c_meta_r <= b_meta_r;
    d_meta_r <= c_meta_r;
    for (int i = 0; i < 3; i++) begin
      a_mag_r[i] <= in_mag[i];
      b_sq_r[i]  <= SQ_W'(a_mag_r[i]) * SQ_W'(a_mag_r[i]);
    end
    c_part_r <= b_sq_r[0] + b_sq_r[1];
    c_sq2_r  <= b_sq_r[2];
    d_sum_r  <= c_part_r + c_sq2_r;
    s_meta_r[0] <= d_meta_r;
    for (int k = 1; k <= SQ_STAGES; k++) begin
      s_meta_r[k] <= s_meta_r[k-1];
    end
    for (int k = 0; k <= SQ_STAGES; k++) begin
      s_rad_r[k]  <= s_rad_nxt[k];
      s_rem_r[k]  <= s_rem_nxt[k];
      s_root_r[k] <= s_root_nxt[k];
    end
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
    out_z_r <= out_z_nxt;
    out_w_r <= out_w_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_quat_x = out_x_r;
  assign out_quat_y = out_y_r;
  assign out_quat_z = out_z_r;
  assign out_quat_w = out_w_r;

endmodule

// File: bench/tb_quaternion_omitted_component_restore.sv
// Self-checking bench for the smallest-three quaternion restore block.
// Drives directed and random transactions and compares every restored quaternion
// with an in-bench prediction. Depends on qocr_pkg and the block's top level.
module tb_quaternion_omitted_component_restore;
  timeunit 1ns;
  timeprecision 1ps;

  import qocr_pkg::*;

  // Acceptance-to-result latency of the block, used to size the final drain wait.
  localparam int LATENCY = 21;
  // Cycles without any accepted transaction or result before the run is abandoned.
  // A correct run never waits longer than a sender gap plus the latency.
  localparam int WATCHDOG_LIMIT = 1000;
  // Transactions per random phase; four phases give about 1100 in all.
  localparam int PHASE_ITEMS = 275;

  // One in fixed point, and the largest magnitude that keeps three equal
  // components inside the unit sphere (one over the square root of three).
  localparam comp_t Q_ONE = comp_t'(1) <<< FRAC_BITS;
  localparam comp_t Q_HALF = Q_ONE >>> 1;
  localparam int unsigned UNIT_THIRD = 619925131;
  localparam comp_t COMP_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam comp_t COMP_MAX = {1'b0, {(DW-1){1'b1}}};

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t w;
  } quat_t;

  // Holds the quaternions that accepted transactions should produce, in order,
  // and checks each strobed result against the oldest one.
  class restored_quat_book;
    quat_t expected_quats[$];
    int accepted;
    int checked;
    int mismatches;

    // Places the three sent components and rebuilds the omitted one as the
    // floor square root of one minus the exact sum of squares.
    function automatic quat_t restore(logic [IDX_W-1:0] idx, comp_t c0, comp_t c1, comp_t c2);
      comp_t sent [3];
      comp_t slot [4];
      logic signed [SQ_W-1:0] wide;
      logic [SQ_W-1:0] mag;
      logic [SQ_W-1:0] sq_sum;
      logic [SQ_W-1:0] radicand;
      logic [SQ_W-1:0] trial;
      logic [SQ_W-1:0] root;
      int k;
      quat_t q;
      sent = '{c0, c1, c2};
      slot = '{default: '0};
      sq_sum = '0;
      root = '0;
      k = 0;
      if (idx <= IDX_MAX) begin
        for (int j = 0; j < 4; j++) begin
          if (j != int'(idx)) begin
            slot[j] = sent[k];
            wide = SQ_W'(sent[k]);
            mag = (wide < 0) ? -wide : wide;
            sq_sum += mag * mag;
            k++;
          end
        end
        // A sum at or above one clamps the rebuilt component to zero.
        if (sq_sum < ONE_SQ) begin
          radicand = ONE_SQ - sq_sum;
          for (int b = FRAC_BITS + 1; b >= 0; b--) begin
            trial = root | (SQ_W'(1) << b);
            if (trial * trial <= radicand) root = trial;
          end
        end
        slot[idx[1:0]] = comp_t'(root);
      end
      q.x = slot[0];
      q.y = slot[1];
      q.z = slot[2];
      q.w = slot[3];
      return q;
    endfunction

    function void note_accepted(logic [IDX_W-1:0] idx, comp_t c0, comp_t c1, comp_t c2);
      expected_quats.push_back(restore(idx, c0, c1, c2));
      accepted++;
    endfunction

    function void report(string field, comp_t exp_v, comp_t act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch in %s at %0t: expected %h, got %h", field, $time, exp_v, act_v);
    endfunction

    function void check_restored(quat_t act);
      quat_t exp_q;
      if (expected_quats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected restored quaternion at %0t: %h", $time, act);
        return;
      end
      exp_q = expected_quats.pop_front();
      checked++;
      if (act.x !== exp_q.x) report("quat_x", exp_q.x, act.x);
      if (act.y !== exp_q.y) report("quat_y", exp_q.y, act.y);
      if (act.z !== exp_q.z) report("quat_z", exp_q.z, act.z);
      if (act.w !== exp_q.w) report("quat_w", exp_q.w, act.w);
    endfunction

    function int pending();
      return expected_quats.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [IDX_W-1:0] in_omitted_index = '0;
  comp_t in_comp_first = '0;
  comp_t in_comp_second = '0;
  comp_t in_comp_third = '0;
  logic out_valid;
  comp_t out_quat_x;
  comp_t out_quat_y;
  comp_t out_quat_z;
  comp_t out_quat_w;

  restored_quat_book book = new();
  int idle_pct = 0;
  int quiet_cycles = 0;
  int directed_items = 0;

  always #1 clk = ~clk;

  quaternion_omitted_component_restore uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_omitted_index (in_omitted_index),
    .in_comp_first    (in_comp_first),
    .in_comp_second   (in_comp_second),
    .in_comp_third    (in_comp_third),
    .out_valid        (out_valid),
    .out_quat_x       (out_quat_x),
    .out_quat_y       (out_quat_y),
    .out_quat_z       (out_quat_z),
    .out_quat_w       (out_quat_w)
  );

  // Monitor. Inputs change only at the falling edge, so at the rising edge the
  // transaction fields and the result ports are stable. A transaction is taken
  // when start is high and busy is low. The result channel cannot be stalled, so
  // every strobe is a result. The watchdog counts edges with no progress at all.
  always @(posedge clk) begin : monitor
    logic progress;
    progress = 1'b0;
    if (rst_n && start && !busy) begin
      book.note_accepted(in_omitted_index, in_comp_first, in_comp_second, in_comp_third);
      progress = 1'b1;
    end
    if (rst_n && out_valid) begin
      book.check_restored('{out_quat_x, out_quat_y, out_quat_z, out_quat_w});
      progress = 1'b1;
    end
    quiet_cycles = progress ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction or result for %0d cycles, %0d results pending",
               quiet_cycles, book.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Presents one transaction and holds it until the block takes it. Before it,
  // start may drop for a random gap according to the current idle percentage;
  // when there is no gap start simply stays high from the previous transaction.
  task automatic send(logic [IDX_W-1:0] idx, comp_t c0, comp_t c1, comp_t c2);
    int gap;
    @(negedge clk);
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_omitted_index <= idx;
    in_comp_first <= c0;
    in_comp_second <= c1;
    in_comp_third <= c2;
    do @(posedge clk); while (busy);
  endtask

  // Random magnitude up to the given span with a random sign.
  function automatic comp_t signed_pick(int unsigned span);
    comp_t v;
    v = comp_t'($urandom_range(0, span));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // Most random transactions are well-formed: an index naming a component and
  // three components that stay inside the unit sphere. The rest push the sum of
  // squares past one, use the whole 32-bit range, or carry an index above three.
  task automatic send_random();
    int pick;
    logic [IDX_W-1:0] idx;
    comp_t c0, c1, c2;
    pick = $urandom_range(0, 99);
    idx = IDX_W'($urandom_range(0, int'(IDX_MAX)));
    if (pick < 65) begin
      c0 = signed_pick(UNIT_THIRD);
      c1 = signed_pick(UNIT_THIRD);
      c2 = signed_pick(UNIT_THIRD);
    end else if (pick < 80) begin
      // Unit-range components: the sum lands on both sides of one.
      c0 = signed_pick(Q_ONE);
      c1 = signed_pick(Q_ONE);
      c2 = signed_pick(Q_ONE);
    end else begin
      c0 = comp_t'($urandom());
      c1 = comp_t'($urandom());
      c2 = comp_t'($urandom());
      if (pick >= 90) idx = IDX_W'($urandom_range(0, 255));
    end
    send(idx, c0, c1, c2);
  endtask

  initial begin : stimulus
    int phase_idle [4];
    phase_idle = '{0, 49, 15, 0};

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed transactions: every omitted slot, the rebuilt value at exactly
    // one, a sum of squares exactly one and just below it, out-of-range and
    // extreme components, and indexes above three that must give zeros.
    send(IDX_W'(OMIT_X), '0, '0, '0);
    send(IDX_W'(OMIT_Y), '0, '0, '0);
    send(IDX_W'(OMIT_Z), '0, '0, '0);
    send(IDX_W'(OMIT_W), '0, '0, '0);
    send(IDX_W'(OMIT_X), Q_HALF, -Q_HALF, Q_HALF);
    send(IDX_W'(OMIT_Y), -Q_HALF, Q_HALF, -Q_HALF);
    send(IDX_W'(OMIT_Z), Q_HALF, Q_HALF, -Q_HALF);
    send(IDX_W'(OMIT_W), -Q_HALF, -Q_HALF, Q_HALF);
    send(IDX_W'(OMIT_W), Q_ONE, '0, '0);
    send(IDX_W'(OMIT_Y), Q_ONE - 1, '0, '0);
    send(IDX_W'(OMIT_X), '0, -Q_ONE, '0);
    send(IDX_W'(OMIT_Y), '0, '0, comp_t'(1));
    send(IDX_W'(OMIT_X), comp_t'(1), comp_t'(-1), '0);
    send(IDX_W'(OMIT_Z), COMP_MIN, COMP_MAX, comp_t'(-1));
    send(IDX_W'(OMIT_X), COMP_MAX, COMP_MAX, COMP_MAX);
    send(IDX_W'(OMIT_W), COMP_MIN, COMP_MIN, COMP_MIN);
    send(IDX_W'(IDX_MAX + 1), Q_HALF, Q_HALF, Q_HALF);
    send({IDX_W{1'b1}}, COMP_MIN, COMP_MAX, comp_t'(-1));
    send(IDX_W'(8'h80), Q_ONE, -Q_HALF, COMP_MAX);
    send(IDX_W'(8'h7c), comp_t'(-1), COMP_MIN, Q_ONE);
    directed_items = book.accepted;

    // Random phases: back to back, sender idle about half the time, sender
    // idle now and then, and back to back again. The result side has no
    // stall to exercise since the block cannot be held off.
    foreach (phase_idle[p]) begin
      idle_pct = phase_idle[p];
      repeat (PHASE_ITEMS) send_random();
    end

    @(negedge clk);
    start <= 1'b0;

    // Drain the pipeline, then give any stray strobe time to show up.
    while (book.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    $display("Restored %0d quaternions from %0d transactions (%0d directed, rest random).",
             book.checked, book.accepted, directed_items);
    $display("Sender idle phases of 0, 49, 15 and 0 percent; %0d field mismatches.",
             book.mismatches);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
